[hdl/html_link_extractor_macros.svh]
// Assertion macros for the link extractor RTL.
`ifndef HTML_LINK_EXTRACTOR_MACROS_SVH
`define HTML_LINK_EXTRACTOR_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define HLE_ASSERT_HOLDS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define HLE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

[hdl/hle_pkg.sv]
// Types, constants and character helpers for the HTML link extractor.
`default_nettype none
package hle_pkg;
	localparam int BUFFER_BYTES = 4096;
	localparam int ABITS = $clog2(BUFFER_BYTES);
	localparam int PBITS = 13;
	localparam logic [PBITS-1:0] BUF_LIMIT = PBITS'(BUFFER_BYTES);

	typedef enum logic [1:0] {
		FN_LOAD    = 2'd0,
		FN_RESTART = 2'd1,
		FN_FETCH   = 2'd2,
		FN_NOP     = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		K_AREA   = 3'd0,
		K_A      = 3'd1,
		K_BASE   = 3'd2,
		K_LINK   = 3'd3,
		K_FRAME  = 3'd4,
		K_IFRAME = 3'd5,
		K_IMG    = 3'd6
	} kind_t;

	typedef struct packed {
		logic             wr;
		logic             restart;
		logic             fetch;
		logic [ABITS-1:0] addr;
		logic [7:0]       data;
	} cmd_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [2:0]       kind;
		logic [PBITS-1:0] url_start;
		logic [PBITS-1:0] url_end;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] kind;
		logic [2:0] len;
	} tag_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	// Bytes are folded, index 0 is the first byte after the '<'.
	function automatic tag_t tag_match(input logic [6:0][7:0] t);
		tag_t r;
		r.kind = K_AREA;
		r.len  = 3'd4;
		if (t[0] == "a" && t[1] == "r" && t[2] == "e" && t[3] == "a") begin
			r.kind = K_AREA;   r.len = 3'd4;
		end else if (t[0] == "a") begin
			r.kind = K_A;      r.len = 3'd1;
		end else if (t[0] == "b" && t[1] == "a" && t[2] == "s" && t[3] == "e") begin
			r.kind = K_BASE;   r.len = 3'd4;
		end else if (t[0] == "l" && t[1] == "i" && t[2] == "n" && t[3] == "k") begin
			r.kind = K_LINK;   r.len = 3'd4;
		end else if (t[0] == "f" && t[1] == "r" && t[2] == "a" && t[3] == "m"
				&& t[4] == "e") begin
			r.kind = K_FRAME;  r.len = 3'd5;
		end else if (t[0] == "i" && t[1] == "f" && t[2] == "r" && t[3] == "a"
				&& t[4] == "m" && t[5] == "e") begin
			r.kind = K_IFRAME; r.len = 3'd6;
		end else if (t[0] == "i" && t[1] == "m" && t[2] == "g") begin
			r.kind = K_IMG;    r.len = 3'd3;
		end else begin
			r.len = 3'd0;
		end
		r.ok = (r.len != 3'd0) && is_ws(t[r.len]);
		return r;
	endfunction
endpackage
`default_nettype wire

[hdl/hle_scan.sv]
// Page buffer and byte-serial link scan sequencer.
`default_nettype none
module hle_scan (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire hle_pkg::cmd_t           cmd,
	input  wire logic [hle_pkg::PBITS-1:0] lim,
	output logic                         busy,
	output hle_pkg::res_t                res
);
	typedef enum logic [16:0] {
		S_IDLE = 17'h00001, S_FIND = 17'h00002, S_LT1  = 17'h00004,
		S_LT2  = 17'h00008, S_LT3  = 17'h00010, S_EL   = 17'h00020,
		S_CDD  = 17'h00040, S_CDD2 = 17'h00080, S_CWS  = 17'h00100,
		S_CWS2 = 17'h00200, S_TAG  = 17'h00400, S_TCHK = 17'h00800,
		S_PAT  = 17'h01000, S_WS1  = 17'h02000, S_WS2  = 17'h04000,
		S_URL  = 17'h08000, S_DONE = 17'h10000
	} state_t;

	localparam int PB = hle_pkg::PBITS;

	logic [7:0]    mem [hle_pkg::BUFFER_BYTES];
	logic [7:0]    rdata_q;
	logic [PB-1:0] prev_q;
	logic          fresh_q;
	state_t        state_q;
	logic [PB-1:0] ptr_q, lt_q, en_q, pos_q, us_q;
	logic [2:0]    cnt_q, kind_q;
	logic [7:0]    endc_q;
	logic          found_q;
	logic [6:0][7:0] tag_q;
	logic [3:0][7:0] win_q;

	logic          vld;
	logic [7:0]    c, fc, mc;
	logic [3:0][7:0] nw;
	logic          pat_hit;
	hle_pkg::tag_t tr;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[cmd.addr] <= cmd.data;
		end
		rdata_q <= mem[ptr_q[hle_pkg::ABITS-1:0]];
	end

	assign vld = fresh_q && (prev_q == ptr_q);
	assign c   = rdata_q;
	assign fc  = hle_pkg::fold(rdata_q);
	assign mc  = hle_pkg::is_ws(rdata_q) ? 8'd32 : rdata_q;
	assign nw  = {fc, win_q[3:1]};
	assign tr  = hle_pkg::tag_match(tag_q);

	always_comb begin
		if (kind_q <= hle_pkg::K_LINK) begin
			pat_hit = (cnt_q >= 3'd3) && nw[0] == "h" && nw[1] == "r" && nw[2] == "e"
				&& nw[3] == "f";
		end else begin
			pat_hit = (cnt_q >= 3'd2) && nw[1] == "s" && nw[2] == "r" && nw[3] == "c";
		end
	end

	assign busy = (state_q != S_IDLE);
	assign res.done      = (state_q == S_DONE);
	assign res.found     = found_q;
	assign res.kind      = kind_q;
	assign res.url_start = us_q;
	assign res.url_end   = ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fresh_q <= 1'b0;
			prev_q  <= '0;
			ptr_q   <= '0;
			lt_q    <= '0;
			en_q    <= '0;
			pos_q   <= '0;
			us_q    <= '0;
			cnt_q   <= '0;
			kind_q  <= '0;
			endc_q  <= '0;
			found_q <= 1'b0;
			tag_q   <= '0;
			win_q   <= '0;
		end else begin
			prev_q  <= ptr_q;
			fresh_q <= (state_q != S_IDLE);
			unique case (state_q)
				S_IDLE: begin
					if (cmd.restart) begin
						pos_q <= '0;
					end
					if (cmd.fetch) begin
						ptr_q   <= pos_q;
						found_q <= 1'b0;
						kind_q  <= '0;
						us_q    <= '0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (ptr_q >= lim) begin
						found_q <= 1'b0;
						kind_q  <= '0;
						us_q    <= '0;
						ptr_q   <= '0;
						state_q <= S_DONE;
					end else if (vld) begin
						if (c == "<") begin
							lt_q    <= ptr_q;
							ptr_q   <= ptr_q + 1'b1;
							state_q <= (ptr_q + PB'(2) < lim) ? S_LT1 : S_EL;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_LT1: begin
					if (vld) begin
						if (c == "!") begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_LT2;
						end else begin
							state_q <= S_EL;
						end
					end
				end
				S_LT2: begin
					if (vld) begin
						if (c == ">") begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_FIND;
						end else if (c == "-" && lt_q + PB'(3) < lim) begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_LT3;
						end else begin
							ptr_q   <= lt_q + 1'b1;
							state_q <= S_EL;
						end
					end
				end
				S_LT3: begin
					if (vld) begin
						if (c == "-") begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_CDD;
						end else begin
							ptr_q   <= lt_q + 1'b1;
							state_q <= S_EL;
						end
					end
				end
				S_CDD: begin
					if (ptr_q + 1'b1 >= lim) begin
						ptr_q   <= '0;
						state_q <= S_DONE;
					end else if (vld) begin
						ptr_q <= ptr_q + 1'b1;
						if (c == "-") begin
							state_q <= S_CDD2;
						end
					end
				end
				S_CDD2: begin
					if (vld) begin
						if (c == "-") begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_CWS;
						end else begin
							state_q <= S_CDD;
						end
					end
				end
				S_CWS: begin
					if (ptr_q >= lim) begin
						ptr_q   <= lt_q + 1'b1;
						state_q <= S_EL;
					end else if (vld) begin
						if (hle_pkg::is_ws(c)) begin
							ptr_q <= ptr_q + 1'b1;
						end else if (c == ">") begin
							state_q <= S_FIND;
						end else if (c == "-" && ptr_q + 1'b1 < lim) begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_CWS2;
						end else begin
							ptr_q   <= lt_q + 1'b1;
							state_q <= S_EL;
						end
					end
				end
				S_CWS2: begin
					if (vld) begin
						if (c == "-") begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_CDD;
						end else begin
							ptr_q   <= lt_q + 1'b1;
							state_q <= S_EL;
						end
					end
				end
				S_EL: begin
					if (ptr_q >= lim) begin
						ptr_q   <= '0;
						state_q <= S_DONE;
					end else if (vld) begin
						if (c == ">") begin
							en_q  <= ptr_q;
							pos_q <= ptr_q + 1'b1;
							if (ptr_q - lt_q < PB'(9)) begin
								ptr_q   <= ptr_q + 1'b1;
								state_q <= S_FIND;
							end else begin
								ptr_q   <= lt_q + 1'b1;
								cnt_q   <= '0;
								state_q <= S_TAG;
							end
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_TAG: begin
					if (vld) begin
						tag_q <= {fc, tag_q[6:1]};
						ptr_q <= ptr_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == 3'd6) begin
							state_q <= S_TCHK;
						end
					end
				end
				S_TCHK: begin
					if (!tr.ok) begin
						ptr_q   <= pos_q;
						state_q <= S_FIND;
					end else begin
						kind_q  <= tr.kind;
						ptr_q   <= lt_q + PB'(tr.len) + PB'(2);
						cnt_q   <= '0;
						state_q <= S_PAT;
					end
				end
				S_PAT: begin
					if (ptr_q >= en_q) begin
						ptr_q   <= pos_q;
						state_q <= S_FIND;
					end else if (vld) begin
						win_q <= nw;
						ptr_q <= ptr_q + 1'b1;
						if (cnt_q != 3'd7) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (pat_hit) begin
							state_q <= S_WS1;
						end
					end
				end
				S_WS1: begin
					if (ptr_q >= en_q) begin
						ptr_q   <= pos_q;
						state_q <= S_FIND;
					end else if (vld) begin
						if (hle_pkg::is_ws(c)) begin
							ptr_q <= ptr_q + 1'b1;
						end else if (c == "=") begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_WS2;
						end else begin
							ptr_q   <= pos_q;
							state_q <= S_FIND;
						end
					end
				end
				S_WS2: begin
					if (ptr_q >= en_q) begin
						ptr_q   <= pos_q;
						state_q <= S_FIND;
					end else if (vld) begin
						if (hle_pkg::is_ws(c)) begin
							ptr_q <= ptr_q + 1'b1;
						end else if (c == "'" || c == "\"") begin
							endc_q  <= c;
							ptr_q   <= ptr_q + 1'b1;
							us_q    <= ptr_q + 1'b1;
							state_q <= S_URL;
						end else begin
							endc_q  <= 8'd32;
							us_q    <= ptr_q;
							state_q <= S_URL;
						end
					end
				end
				S_URL: begin
					if (ptr_q >= en_q) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else if (vld) begin
						if (mc != endc_q) begin
							ptr_q <= ptr_q + 1'b1;
						end else begin
							found_q <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/html_link_extractor.sv]
// HTML link extractor: page buffer load, scan restart and link fetch.
// Usage: software sets the page length on the cfg channel, loads page bytes
// with load beats on the s channel, then issues a restart beat and fetch beats.
// Every s beat produces exactly one m beat. Load, restart and no-op beats
// answer with an all-zero result in the cycle after acceptance.
// A fetch walks the buffer through the single read port of the page memory,
// under a small sequencer; every byte read first registers the memory data
// and is then examined. Bytes of an element that may hold a link are read a
// second time for the tag name and the attribute. One beat is in flight at a
// time.
// s_tready is low while a fetch runs and while an unconsumed result is held
// and m_tready is low; the result stays on m until taken.
// Reset clears the scan position and the page length to zero; the buffer
// contents are undefined until written.
`default_nettype none
`include "html_link_extractor_macros.svh"
module html_link_extractor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // byte_address[11:0], byte_value[19:12], zero pad
	input  wire logic [1:0]  s_tuser,  // func[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // url_start[12:0], url_end[25:13], zero pad
	output logic [3:0]       m_tuser,  // link_found[0], link_kind[3:1]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [12:0] cfg_data  // page_length[12:0]
);
	localparam int PB = hle_pkg::PBITS;

	logic [PB-1:0]  plen_q;
	logic [PB-1:0]  lim;
	logic           busy;
	logic           accept;
	hle_pkg::cmd_t  cmd;
	hle_pkg::res_t  res;
	logic           ov_q;
	logic           found_q;
	logic [2:0]     kind_q;
	logic [PB-1:0]  us_q, ue_q;

	assign cfg_ready = 1'b1;
	assign lim = (plen_q < hle_pkg::BUF_LIMIT) ? plen_q : hle_pkg::BUF_LIMIT;

	assign s_tready = !busy && (!ov_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign cmd.wr      = accept && (s_tuser == hle_pkg::FN_LOAD);
	assign cmd.restart = accept && (s_tuser == hle_pkg::FN_RESTART);
	assign cmd.fetch   = accept && (s_tuser == hle_pkg::FN_FETCH);
	assign cmd.addr    = s_tdata[hle_pkg::ABITS-1:0];
	assign cmd.data    = s_tdata[19:12];

	hle_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.lim    (lim),
		.busy   (busy),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= '0;
			ov_q    <= 1'b0;
			found_q <= 1'b0;
			kind_q  <= '0;
			us_q    <= '0;
			ue_q    <= '0;
		end else begin
			if (cfg_valid) begin
				plen_q <= cfg_data;
			end
			if (res.done) begin
				ov_q    <= 1'b1;
				found_q <= res.found;
				kind_q  <= res.found ? res.kind : 3'd0;
				us_q    <= res.found ? res.url_start : '0;
				ue_q    <= res.found ? res.url_end : '0;
			end else if (accept && !cmd.fetch) begin
				ov_q    <= 1'b1;
				found_q <= 1'b0;
				kind_q  <= '0;
				us_q    <= '0;
				ue_q    <= '0;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {6'd0, ue_q, us_q};
	assign m_tuser  = {kind_q, found_q};

	`HLE_ASSERT_IMPL(a_ready_idle, s_tready, !busy)
	`HLE_ASSERT_IMPL(a_url_order, m_tvalid && m_tuser[0], m_tdata[25:13] >= m_tdata[12:0])
	`HLE_ASSERT_IMPL(a_nolink_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0 && m_tuser == 4'd0)
endmodule
`default_nettype wire

[sim/html_link_extractor_tb.sv]
// Self-checking testbench for the HTML link extractor with a scanning predictor.
module html_link_extractor_tb;
	typedef struct packed {
		logic        found;
		logic [2:0]  kind;
		logic [12:0] url_start;
		logic [12:0] url_end;
	} link_res_t;

	typedef struct {
		hle_pkg::func_t fn;
		logic [11:0]    addr;
		logic [7:0]     val;
		bit             typed;
		link_res_t      res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data = '0;

	logic [7:0]  page_model [hle_pkg::BUFFER_BYTES];
	int          scan_pos;
	int          page_len;
	link_res_t   link_q [$];
	link_res_t   last_link;
	int          mismatches;
	bit          failed;
	int          burst_left;
	int          results_seen;
	int          hold_cnt;
	bit          held;
	int          rx_mode;
	int          rx_cnt;
	logic [7:0]  frag_q [$];

	string frag_lib [] = '{
		"<a href=\"x.html\">", "<A HREF='q r'>", "<img src=pic.png alt>",
		"<iframe\tsrc = \"f\">", "<frame src=>", "<base href=b>",
		"<link rel href = l >", "<area shape href=\"ar\">", "<!-- c -- -- d -->",
		"<!-- c --  >", "<!-- bad -- x> <a href=y>", "<!>", "<a>", "<ab href=zz>",
		"<a\nhref='open>", "<img nosrc>", "<p class=x>", " text ", "<b href=x>",
		"<frame\nsrc='z'  >", "<!--", "<a href=\"", "\n\t", "<img  src\t=\t\"s t\">",
		"<area href>", "<a href = >"
	};

	html_link_extractor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit white(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] page_byte(input int i);
		return (i < hle_pkg::BUFFER_BYTES) ? page_model[i] : 8'd0;
	endfunction

	function automatic bit next_element(input int lim, output int st, output int en);
		int s;
		int e;
		int t;
		bit rev;
		s = scan_pos;
		st = 0;
		en = 0;
		if (s >= lim)
			return 0;
		while (1) begin
			while (s < lim && page_byte(s) != "<")
				s++;
			if (s >= lim)
				return 0;
			if (s + 2 < lim && page_byte(s + 1) == "!" && page_byte(s + 2) == ">") begin
				s += 3;
				continue;
			end
			if (s + 3 < lim && page_byte(s + 1) == "!" && page_byte(s + 2) == "-"
					&& page_byte(s + 3) == "-") begin
				t = s + 4;
				rev = 0;
				while (1) begin
					while (t + 1 < lim && !(page_byte(t) == "-" && page_byte(t + 1) == "-"))
						t++;
					if (t + 1 >= lim)
						return 0;
					t += 2;
					while (t < lim && white(page_byte(t)))
						t++;
					if (t < lim && page_byte(t) == ">")
						break;
					if (t + 1 < lim && page_byte(t) == "-" && page_byte(t + 1) == "-") begin
						t += 2;
						continue;
					end
					rev = 1;
					break;
				end
				if (!rev) begin
					s = t;
					continue;
				end
			end
			break;
		end
		e = s + 1;
		while (e < lim && page_byte(e) != ">")
			e++;
		if (e >= lim)
			return 0;
		st = s + 1;
		en = e;
		scan_pos = e + 1;
		return 1;
	endfunction

	function automatic bit element_link(input int st, input int en, output link_res_t r);
		string names [7] = '{"area", "a", "base", "link", "frame", "iframe", "img"};
		string pat;
		int k;
		int s;
		int p;
		bit ok;
		logic [7:0] endc;
		logic [7:0] c;
		r = '0;
		k = -1;
		if (en - st < 8)
			return 0;
		for (int i = 0; i < 7 && k < 0; i++) begin
			ok = 1;
			for (int j = 0; j < names[i].len(); j++)
				if (lower(page_byte(st + j)) != names[i][j])
					ok = 0;
			if (ok)
				k = i;
		end
		if (k < 0)
			return 0;
		s = st + names[k].len();
		if (s >= en || !white(page_byte(s)))
			return 0;
		s++;
		if (s >= en)
			return 0;
		pat = (k <= hle_pkg::K_LINK) ? "href" : "src";
		for (p = s; p + pat.len() <= en; p++) begin
			ok = 1;
			for (int j = 0; j < pat.len(); j++)
				if (lower(page_byte(p + j)) != pat[j])
					ok = 0;
			if (ok)
				break;
		end
		if (p + pat.len() > en)
			return 0;
		s = p + pat.len();
		while (s < en && white(page_byte(s)))
			s++;
		if (s >= en || page_byte(s) != "=")
			return 0;
		s++;
		while (s < en && white(page_byte(s)))
			s++;
		if (s >= en)
			return 0;
		endc = " ";
		if (page_byte(s) == "'" || page_byte(s) == "\"") begin
			endc = page_byte(s);
			s++;
		end
		r.url_start = 13'(s);
		while (s < en) begin
			c = white(page_byte(s)) ? 8'd32 : page_byte(s);
			if (c == endc)
				break;
			s++;
		end
		r.url_end = 13'(s);
		r.kind = 3'(k);
		r.found = 1'b1;
		return 1;
	endfunction

	function automatic link_res_t predict_link(input hle_pkg::func_t fn,
			input logic [11:0] addr, input logic [7:0] val);
		link_res_t r;
		int lim;
		int st;
		int en;
		r = '0;
		case (fn)
			hle_pkg::FN_LOAD: begin
				page_model[addr] = val;
			end
			hle_pkg::FN_RESTART: begin
				scan_pos = 0;
			end
			hle_pkg::FN_FETCH: begin
				lim = (page_len < hle_pkg::BUFFER_BYTES) ? page_len : hle_pkg::BUFFER_BYTES;
				while (next_element(lim, st, en))
					if (element_link(st, en, r))
						break;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_beat(input hle_pkg::func_t fn, input logic [11:0] addr,
			input logic [7:0] val, input bit typed = 0, input link_res_t typed_res = '0);
		link_res_t r;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {4'b0, val, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_link(fn, addr, val);
		last_link = r;
		link_q.push_back(typed ? typed_res : r);
		burst_left--;
	endtask

	task automatic set_page_length(input logic [12:0] v);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (link_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		page_len = v;
	endtask

	task automatic build_page(input int n);
		string f;
		logic [7:0] c;
		frag_q.delete();
		while (frag_q.size() < n) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 4))
						0: frag_q.push_back("<");
						1: frag_q.push_back("-");
						2: frag_q.push_back(">");
						default: frag_q.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end else begin
				f = frag_lib[$urandom_range(0, frag_lib.size() - 1)];
				for (int i = 0; i < f.len(); i++) begin
					c = f[i];
					if (lower(c) >= "a" && lower(c) <= "z" && $urandom_range(0, 1))
						c = c ^ 8'h20;
					frag_q.push_back(c);
				end
			end
		end
		for (int i = 0; i < n; i++)
			send_beat(hle_pkg::FN_LOAD, 12'(i), frag_q[i]);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (link_q.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: tuser=%h tdata=%h", m_tuser, m_tdata);
			end else begin
				if (m_tuser !== {link_q[0].kind, link_q[0].found}
						|| m_tdata !== {6'b0, link_q[0].url_end, link_q[0].url_start}) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected found=%0d kind=%0d start=%0d end=%0d,",
							" got found=%0d kind=%0d start=%0d end=%0d"},
							link_q[0].found, link_q[0].kind, link_q[0].url_start,
							link_q[0].url_end, m_tuser[0], m_tuser[3:1], m_tdata[12:0],
							m_tdata[25:13]);
				end
				void'(link_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		rx_cnt <= rx_cnt + 1;
		if (rx_cnt % 200 == 0)
			rx_mode <= $urandom_range(0, 2);
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (!held && results_seen >= 300) begin
			held <= 1'b1;
			hold_cnt <= 400;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 9) < 7);
				default: m_tready <= (rx_cnt % 3 != 0);
			endcase
		end
	end

	initial begin
		#30000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		stim_row_t rows [9] = '{
			'{hle_pkg::FN_FETCH, 12'd0, 8'd0, 1, '0},
			'{hle_pkg::FN_LOAD, 12'd0, 8'd0, 1, '0},
			'{hle_pkg::FN_LOAD, 12'd4095, 8'd255, 1, '0},
			'{hle_pkg::FN_LOAD, 12'd2048, 8'h5A, 1, '0},
			'{hle_pkg::FN_RESTART, 12'd4095, 8'd255, 1, '0},
			'{hle_pkg::FN_NOP, 12'd4095, 8'd255, 1, '0},
			'{hle_pkg::FN_FETCH, 12'd4095, 8'd255, 1, '0},
			'{hle_pkg::FN_NOP, 12'd0, 8'd0, 0, '0},
			'{hle_pkg::FN_FETCH, 12'd0, 8'd0, 0, '0}
		};
		string link_page;
		int items;
		int misses;
		int n;
		int pick;
		int hi_mark;
		mismatches = 0;
		failed = 0;
		burst_left = 0;
		scan_pos = 0;
		page_len = 0;
		results_seen = 0;
		hold_cnt = 0;
		held = 0;
		rx_mode = 0;
		rx_cnt = 0;
		link_page = "<a href=x.html>";
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_beat(rows[i].fn, rows[i].addr, rows[i].val, rows[i].typed, rows[i].res);

		// A page length above the buffer size is clipped; the fetch stops at the first
		// link, so only the written bytes are read.
		for (int i = 0; i < link_page.len(); i++)
			send_beat(hle_pkg::FN_LOAD, 12'(i), link_page[i]);
		set_page_length(13'd8191);
		send_beat(hle_pkg::FN_RESTART, 12'd0, 8'd0);
		send_beat(hle_pkg::FN_FETCH, 12'd0, 8'd0);
		set_page_length(13'(link_page.len()));
		send_beat(hle_pkg::FN_FETCH, 12'd0, 8'd0, 1, '0);
		hi_mark = link_page.len();

		items = 0;
		while (items < 1250) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(300, 600)
				: $urandom_range(16, 160);
			build_page(n);
			if (n > hi_mark)
				hi_mark = n;
			items += n;
			case ($urandom_range(0, 9))
				0: set_page_length(13'd0);
				1: set_page_length(13'($urandom_range(0, n)));
				2: set_page_length(13'(hi_mark));
				default: set_page_length(13'(n));
			endcase
			send_beat(hle_pkg::FN_RESTART, 12'd0, 8'd0);
			misses = 0;
			while (misses < 2 && items < 1400) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					send_beat(hle_pkg::FN_FETCH, 12'($urandom), 8'($urandom));
					if (!last_link.found)
						misses++;
				end else if (pick < 90)
					send_beat(hle_pkg::FN_LOAD, 12'($urandom), 8'($urandom));
				else if (pick < 95)
					send_beat(hle_pkg::FN_RESTART, 12'($urandom), 8'($urandom));
				else
					send_beat(hle_pkg::FN_NOP, 12'($urandom), 8'($urandom));
				items++;
			end
		end

		s_tvalid <= 1'b0;
		while (link_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
